// File: src/ddq_pkg.sv
// Package for the double-ended queue unit: opcodes, status codes and text entry type.
// No dependencies; every other file of the block imports it.
`timescale 1ns / 1ps

package ddq_pkg;

  localparam int TEXT_LOW_W  = 64;
  localparam int TEXT_HIGH_W = 56;

  typedef enum logic [2:0] {
    OP_PUSH_FRONT = 3'd0,
    OP_PUSH_BACK  = 3'd1,
    OP_POP_FRONT  = 3'd2,
    OP_POP_BACK   = 3'd3,
    OP_DUMP_FWD   = 3'd4,
    OP_DUMP_BWD   = 3'd5
  } opcode_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  typedef struct packed {
    logic [TEXT_HIGH_W-1:0] high;
    logic [TEXT_LOW_W-1:0]  low;
  } text_t;

  typedef struct packed {
    logic we;
    logic re;
  } mem_ctl_t;

endpackage

// File: src/ddq_if.sv
// Request and response channel interfaces of the double-ended queue unit.
// Depends on ddq_pkg for the field widths.
`timescale 1ns / 1ps

interface ddq_req_if
  import ddq_pkg::*;
();
  logic                   valid;
  logic                   ready;
  logic [2:0]             opcode;
  logic [TEXT_LOW_W-1:0]  text_low;
  logic [TEXT_HIGH_W-1:0] text_high;

  modport source (output valid, opcode, text_low, text_high, input ready);
  modport sink   (input valid, opcode, text_low, text_high, output ready);
endinterface

interface ddq_rsp_if
  import ddq_pkg::*;
#(
  parameter int PW = 5
) ();
  logic                   valid;
  logic                   ready;
  logic [1:0]             status;
  logic [TEXT_LOW_W-1:0]  out_text_low;
  logic [TEXT_HIGH_W-1:0] out_text_high;
  logic [PW-1:0]          position;
  logic                   last;

  modport source (output valid, status, out_text_low, out_text_high, position, last,
                  input ready);
  modport sink   (input valid, status, out_text_low, out_text_high, position, last,
                  output ready);
endinterface

// File: src/ddq_store.sv
// Ring store of text entries: one write port, one read port, registered read data.
// Depends on ddq_pkg for text_t and mem_ctl_t.
`timescale 1ns / 1ps

module ddq_store
  import ddq_pkg::*;
#(
  parameter int DEPTH = 16,
  parameter int AW    = 4
) (
  input  logic          clk_i,
  input  mem_ctl_t      ctl_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [AW-1:0] raddr_i,
  input  text_t         wdata_i,
  output text_t         rdata_o
);

  text_t mem [DEPTH];
  text_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (ctl_i.we) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.re) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: src/ddq_ctrl.sv
// Queue controller: front index and entry count, push/pop updates, read-out sequencer
// and response register. Depends on ddq_pkg; drives the ddq_store ports.
`timescale 1ns / 1ps

module ddq_ctrl
  import ddq_pkg::*;
#(
  parameter int DEPTH = 16,
  parameter int AW    = 4,
  parameter int CW    = 5
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          req_valid_i,
  output logic          req_ready_o,
  input  logic [2:0]    req_opcode_i,
  input  text_t         req_text_i,
  output logic          rsp_valid_o,
  input  logic          rsp_ready_i,
  output status_e       rsp_status_o,
  output text_t         rsp_text_o,
  output logic [CW-1:0] rsp_position_o,
  output logic          rsp_last_o,
  output mem_ctl_t      mem_ctl_o,
  output logic [AW-1:0] mem_waddr_o,
  output logic [AW-1:0] mem_raddr_o,
  output text_t         mem_wdata_o,
  input  text_t         mem_rdata_i
);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_DUMP = 1'b1;
  localparam int   SW     = CW + 1;

  logic          state_q, state_d;
  logic [AW-1:0] front_q, front_d;
  logic [CW-1:0] count_q, count_d;
  logic [AW-1:0] rd_slot_q, rd_slot_d;
  logic [CW-1:0] rd_left_q, rd_left_d;
  logic [CW-1:0] pos_q, pos_d;
  logic          pend_q, pend_d;
  logic          bwd_q, bwd_d;

  logic          ov_q, ov_d;
  status_e       ostat_q, ostat_d;
  text_t         otext_q, otext_d;
  logic [CW-1:0] opos_q, opos_d;
  logic          olast_q, olast_d;

  function automatic logic [AW-1:0] wrap_slot(input logic [SW-1:0] sum);
    logic [SW-1:0] r;
    r = (sum >= SW'(DEPTH)) ? sum - SW'(DEPTH) : sum;
    return r[AW-1:0];
  endfunction

  function automatic logic [AW-1:0] step_slot(input logic [AW-1:0] s, input logic back);
    logic [AW-1:0] r;
    if (back) begin
      r = (s == '0) ? AW'(DEPTH - 1) : s - AW'(1);
    end else begin
      r = (s == AW'(DEPTH - 1)) ? '0 : s + AW'(1);
    end
    return r;
  endfunction

  logic          out_free;
  logic          accept;
  logic          full;
  logic          empty;
  logic [AW-1:0] front_inc;
  logic [AW-1:0] front_dec;
  logic [AW-1:0] back_free;
  logic [AW-1:0] back_last;
  logic [CW-1:0] pos_next;
  logic          consume;

  assign out_free    = !ov_q || rsp_ready_i;
  assign req_ready_o = (state_q == S_IDLE) && out_free;
  assign accept      = req_valid_i && req_ready_o;
  assign full        = (count_q == CW'(DEPTH));
  assign empty       = (count_q == '0);
  assign front_inc   = step_slot(front_q, 1'b0);
  assign front_dec   = step_slot(front_q, 1'b1);
  assign back_free   = wrap_slot(SW'(front_q) + SW'(count_q));
  assign back_last   = wrap_slot(SW'(front_q) + SW'(count_q) - SW'(1));
  assign pos_next    = pos_q + CW'(1);
  assign consume     = (state_q == S_DUMP) && pend_q && out_free;

  always_comb begin
    state_d     = state_q;
    front_d     = front_q;
    count_d     = count_q;
    rd_slot_d   = rd_slot_q;
    rd_left_d   = rd_left_q;
    pos_d       = pos_q;
    pend_d      = pend_q;
    bwd_d       = bwd_q;
    ov_d        = ov_q && !rsp_ready_i;
    ostat_d     = ostat_q;
    otext_d     = otext_q;
    opos_d      = opos_q;
    olast_d     = olast_q;
    mem_ctl_o   = '0;
    mem_waddr_o = front_q;
    mem_raddr_o = front_q;
    mem_wdata_o = req_text_i;

    if (accept) begin
      case (req_opcode_i)
        OP_PUSH_FRONT, OP_PUSH_BACK: begin
          ov_d    = 1'b1;
          otext_d = '0;
          opos_d  = '0;
          olast_d = 1'b1;
          if (full) begin
            ostat_d = ST_FULL;
          end else begin
            ostat_d      = ST_OK;
            mem_ctl_o.we = 1'b1;
            count_d      = count_q + CW'(1);
            if (req_opcode_i == OP_PUSH_FRONT) begin
              front_d     = front_dec;
              mem_waddr_o = front_dec;
            end else begin
              mem_waddr_o = back_free;
            end
          end
        end
        OP_POP_FRONT, OP_POP_BACK: begin
          ov_d    = 1'b1;
          otext_d = '0;
          opos_d  = '0;
          olast_d = 1'b1;
          if (empty) begin
            ostat_d = ST_EMPTY;
          end else begin
            ostat_d = ST_OK;
            count_d = count_q - CW'(1);
            if (count_q == CW'(1)) begin
              front_d = '0;
            end else if (req_opcode_i == OP_POP_FRONT) begin
              front_d = front_inc;
            end
          end
        end
        OP_DUMP_FWD, OP_DUMP_BWD: begin
          if (empty) begin
            ov_d    = 1'b1;
            ostat_d = ST_EMPTY;
            otext_d = '0;
            opos_d  = '0;
            olast_d = 1'b1;
          end else begin
            bwd_d        = (req_opcode_i == OP_DUMP_BWD);
            mem_ctl_o.re = 1'b1;
            mem_raddr_o  = bwd_d ? back_last : front_q;
            rd_slot_d    = step_slot(mem_raddr_o, bwd_d);
            rd_left_d    = count_q - CW'(1);
            pos_d        = '0;
            pend_d       = 1'b1;
            state_d      = S_DUMP;
          end
        end
        default: begin
        end
      endcase
    end

    if (state_q == S_DUMP) begin
      if (consume) begin
        ov_d    = 1'b1;
        ostat_d = ST_OK;
        otext_d = mem_rdata_i;
        opos_d  = pos_next;
        olast_d = (pos_next == count_q);
        pos_d   = pos_next;
        pend_d  = 1'b0;
        if (pos_next == count_q) begin
          state_d = S_IDLE;
        end
      end
      if ((rd_left_q != '0) && (!pend_q || consume)) begin
        mem_ctl_o.re = 1'b1;
        mem_raddr_o  = rd_slot_q;
        rd_slot_d    = step_slot(rd_slot_q, bwd_q);
        rd_left_d    = rd_left_q - CW'(1);
        pend_d       = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      front_q   <= '0;
      count_q   <= '0;
      rd_slot_q <= '0;
      rd_left_q <= '0;
      pos_q     <= '0;
      pend_q    <= 1'b0;
      bwd_q     <= 1'b0;
      ov_q      <= 1'b0;
    end else begin
      state_q   <= state_d;
      front_q   <= front_d;
      count_q   <= count_d;
      rd_slot_q <= rd_slot_d;
      rd_left_q <= rd_left_d;
      pos_q     <= pos_d;
      pend_q    <= pend_d;
      bwd_q     <= bwd_d;
      ov_q      <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ostat_q <= ostat_d;
    otext_q <= otext_d;
    opos_q  <= opos_d;
    olast_q <= olast_d;
  end

  assign rsp_valid_o    = ov_q;
  assign rsp_status_o   = ostat_q;
  assign rsp_text_o     = otext_q;
  assign rsp_position_o = opos_q;
  assign rsp_last_o     = olast_q;

endmodule

// File: src/double_ended_queue_unit.sv
// Top level of the double-ended queue unit: controller plus ring store.
// Depends on ddq_pkg, ddq_if, ddq_ctrl and ddq_store.
//
//   channel  dir  carries
//   req_i    in   opcode, text_low, text_high
//   rsp_o    out  status, out_text_low, out_text_high, position, last
//
// The status of a push or pop request appears in the response register on the
// next cycle. A read-out fetches the stored entries one at a time through the
// single read port of the store and stalls while the response is not taken.
// Requests are held off while a read-out runs or the response register is full
// and not being taken. Reset clears front index and count; no clearing pass.
`timescale 1ns / 1ps

module double_ended_queue_unit
  import ddq_pkg::*;
#(
  parameter int DEPTH = 16
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  ddq_req_if.sink       req_i,
  ddq_rsp_if.source     rsp_o
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  mem_ctl_t      mem_ctl;
  logic [AW-1:0] mem_waddr;
  logic [AW-1:0] mem_raddr;
  text_t         mem_wdata;
  text_t         mem_rdata;
  text_t         req_text;
  text_t         rsp_text;
  status_e       rsp_status;
  logic [CW-1:0] rsp_position;

  assign req_text.low  = req_i.text_low;
  assign req_text.high = req_i.text_high;

  ddq_ctrl #(
    .DEPTH (DEPTH),
    .AW    (AW),
    .CW    (CW)
  ) u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .req_valid_i    (req_i.valid),
    .req_ready_o    (req_i.ready),
    .req_opcode_i   (req_i.opcode),
    .req_text_i     (req_text),
    .rsp_valid_o    (rsp_o.valid),
    .rsp_ready_i    (rsp_o.ready),
    .rsp_status_o   (rsp_status),
    .rsp_text_o     (rsp_text),
    .rsp_position_o (rsp_position),
    .rsp_last_o     (rsp_o.last),
    .mem_ctl_o      (mem_ctl),
    .mem_waddr_o    (mem_waddr),
    .mem_raddr_o    (mem_raddr),
    .mem_wdata_o    (mem_wdata),
    .mem_rdata_i    (mem_rdata)
  );

  ddq_store #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_store (
    .clk_i   (clk_i),
    .ctl_i   (mem_ctl),
    .waddr_i (mem_waddr),
    .raddr_i (mem_raddr),
    .wdata_i (mem_wdata),
    .rdata_o (mem_rdata)
  );

  assign rsp_o.status        = rsp_status;
  assign rsp_o.out_text_low  = rsp_text.low;
  assign rsp_o.out_text_high = rsp_text.high;
  assign rsp_o.position      = rsp_position;

endmodule

// File: src/ddq_checker.sv
// Port-level checks for the double-ended queue unit, bound to the top level.
// Depends on ddq_pkg for opcodes and status codes.
`timescale 1ns / 1ps

module ddq_checker
  import ddq_pkg::*;
#(
  parameter int DEPTH = 16
) (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          req_valid_i,
  input logic                          req_ready_i,
  input logic [2:0]                    req_opcode_i,
  input logic                          rsp_valid_i,
  input logic                          rsp_ready_i,
  input logic [1:0]                    rsp_status_i,
  input logic [TEXT_LOW_W-1:0]         rsp_text_low_i,
  input logic [TEXT_HIGH_W-1:0]        rsp_text_high_i,
  input logic [$clog2(DEPTH+1)-1:0]    rsp_position_i,
  input logic                          rsp_last_i
);

  // hold a stalled response
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i && $stable(rsp_status_i)
      && $stable(rsp_text_low_i) && $stable(rsp_text_high_i)
      && $stable(rsp_position_i) && $stable(rsp_last_i))
    else $error("stalled response changed");

  // no new request while a read-out is still delivering
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_last_i |-> !req_ready_i)
    else $error("request taken during read-out");

  // push and pop answer with a single status on the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid_i && req_ready_i && (req_opcode_i == OP_PUSH_FRONT
      || req_opcode_i == OP_PUSH_BACK || req_opcode_i == OP_POP_FRONT
      || req_opcode_i == OP_POP_BACK)
    |=> rsp_valid_i && rsp_last_i && rsp_position_i == '0)
    else $error("push or pop status missing");

  // read-out records carry ok status
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && rsp_position_i != '0 |-> rsp_status_i == ST_OK)
    else $error("record with bad status");

endmodule

bind double_ended_queue_unit ddq_checker #(
  .DEPTH (DEPTH)
) u_ddq_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .req_valid_i     (req_i.valid),
  .req_ready_i     (req_i.ready),
  .req_opcode_i    (req_i.opcode),
  .rsp_valid_i     (rsp_o.valid),
  .rsp_ready_i     (rsp_o.ready),
  .rsp_status_i    (rsp_o.status),
  .rsp_text_low_i  (rsp_o.out_text_low),
  .rsp_text_high_i (rsp_o.out_text_high),
  .rsp_position_i  (rsp_o.position),
  .rsp_last_i      (rsp_o.last)
);

// File: tb/tb_double_ended_queue_unit.sv
// Self-checking testbench for double_ended_queue_unit: directed and random push, pop and
// read-out requests, checked against a shadow ring store held in the testbench.
// Depends on ddq_pkg, ddq_if and the RTL of the block.
`timescale 1ns / 1ps

module tb_double_ended_queue_unit;
  import ddq_pkg::*;

  localparam int DEPTH = 16;
  localparam int PW = 5;
  localparam logic [2:0] OP_SPARE_6 = 3'd6;
  localparam logic [2:0] OP_SPARE_7 = 3'd7;
  localparam int CYCLE_LIMIT = 400000;
  localparam int SETTLE_CYCLES = 40;
  localparam int HOLD_OFF_CYCLES = 300;

  typedef struct {
    status_e                status;
    logic [TEXT_LOW_W-1:0]  low;
    logic [TEXT_HIGH_W-1:0] high;
    logic [PW-1:0]          position;
    logic                   last;
  } entry_result_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  ddq_req_if req_if ();
  ddq_rsp_if #(.PW(PW)) rsp_if ();

  double_ended_queue_unit #(.DEPTH(DEPTH)) u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  logic [TEXT_LOW_W-1:0]  ring_low [DEPTH];
  logic [TEXT_HIGH_W-1:0] ring_high[DEPTH];
  logic [3:0]             ring_front;
  logic [4:0]             ring_count;
  entry_result_t          pending_results[$];

  int mismatch_count = 0;
  int cycle_count = 0;
  int hold_left = 0;
  bit idle_on = 1'b1;

  always #5 clk_i = ~clk_i;

  function automatic void expect_result(status_e st, logic [TEXT_LOW_W-1:0] lo,
                                        logic [TEXT_HIGH_W-1:0] hi, logic [PW-1:0] pos,
                                        logic fin);
    entry_result_t r;
    r.status = st;
    r.low = lo;
    r.high = hi;
    r.position = pos;
    r.last = fin;
    pending_results.push_back(r);
  endfunction

  function automatic void predict_request(logic [2:0] op, logic [TEXT_LOW_W-1:0] lo,
                                          logic [TEXT_HIGH_W-1:0] hi);
    logic [3:0] slot;
    case (op)
      OP_PUSH_FRONT, OP_PUSH_BACK: begin
        if (ring_count == DEPTH) begin
          expect_result(ST_FULL, '0, '0, '0, 1'b1);
        end else begin
          if (op == OP_PUSH_FRONT) begin
            ring_front = ring_front - 4'd1;
            slot = ring_front;
          end else begin
            slot = ring_front + ring_count[3:0];
          end
          ring_low[slot] = lo;
          ring_high[slot] = hi;
          ring_count = ring_count + 5'd1;
          expect_result(ST_OK, '0, '0, '0, 1'b1);
        end
      end
      OP_POP_FRONT, OP_POP_BACK: begin
        if (ring_count == 0) begin
          expect_result(ST_EMPTY, '0, '0, '0, 1'b1);
        end else begin
          if (op == OP_POP_FRONT) ring_front = ring_front + 4'd1;
          ring_count = ring_count - 5'd1;
          if (ring_count == 0) ring_front = '0;
          expect_result(ST_OK, '0, '0, '0, 1'b1);
        end
      end
      OP_DUMP_FWD, OP_DUMP_BWD: begin
        if (ring_count == 0) begin
          expect_result(ST_EMPTY, '0, '0, '0, 1'b1);
        end else begin
          for (int i = 0; i < ring_count; i++) begin
            slot = (op == OP_DUMP_FWD) ? ring_front + 4'(i)
                                       : ring_front + 4'(ring_count - 1 - i);
            expect_result(ST_OK, ring_low[slot], ring_high[slot], PW'(i + 1),
                          (i + 1 == ring_count));
          end
        end
      end
      default: ;
    endcase
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    mismatch_count++;
    if (mismatch_count <= 30)
      $display("ERROR at %0t: %s got %h want %h", $time, what, got, want);
  endtask

  task automatic check_response();
    entry_result_t want;
    if (pending_results.size() == 0) begin
      report_mismatch("response with no request pending", 64'(rsp_if.status), '0);
    end else begin
      want = pending_results.pop_front();
      if (rsp_if.status !== want.status)
        report_mismatch("status", 64'(rsp_if.status), 64'(want.status));
      if (rsp_if.out_text_low !== want.low)
        report_mismatch("out_text_low", rsp_if.out_text_low, want.low);
      if (rsp_if.out_text_high !== want.high)
        report_mismatch("out_text_high", 64'(rsp_if.out_text_high), 64'(want.high));
      if (rsp_if.position !== want.position)
        report_mismatch("position", 64'(rsp_if.position), 64'(want.position));
      if (rsp_if.last !== want.last)
        report_mismatch("last", 64'(rsp_if.last), 64'(want.last));
    end
  endtask

  always @(negedge clk_i) begin
    if (rst_ni && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) check_response();
  end

  always @(posedge clk_i) begin
    if (hold_left > 0) begin
      rsp_if.ready <= 1'b0;
      hold_left = hold_left - 1;
    end else if (idle_on) begin
      rsp_if.ready <= ($urandom_range(0, 99) >= 25);
    end else begin
      rsp_if.ready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("double_ended_queue_unit: mismatch");
      $finish;
    end
  end

  function automatic logic [TEXT_LOW_W-1:0] pick_low();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic logic [TEXT_HIGH_W-1:0] pick_high();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      default: return TEXT_HIGH_W'({$urandom, $urandom});
    endcase
  endfunction

  task automatic send_request(logic [2:0] op, logic [TEXT_LOW_W-1:0] lo,
                              logic [TEXT_HIGH_W-1:0] hi);
    int gap;
    bit taken;
    gap = 0;
    if (idle_on && $urandom_range(0, 99) < 25) gap = $urandom_range(1, 5);
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_if.valid <= 1'b1;
    req_if.opcode <= op;
    req_if.text_low <= lo;
    req_if.text_high <= hi;
    taken = 1'b0;
    while (!taken) begin
      @(negedge clk_i);
      taken = (req_if.ready === 1'b1);
      @(posedge clk_i);
    end
    predict_request(op, lo, hi);
  endtask

  task automatic finish_phase();
    req_if.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic test_empty_queue();
    send_request(OP_POP_FRONT, '0, '0);
    send_request(OP_POP_BACK, '1, '1);
    send_request(OP_DUMP_FWD, '0, '0);
    send_request(OP_DUMP_BWD, '1, '1);
    send_request(OP_SPARE_6, '1, '1);
    send_request(OP_SPARE_7, '0, '0);
    finish_phase();
  endtask

  task automatic test_single_entries();
    send_request(OP_PUSH_FRONT, '1, '1);
    send_request(OP_PUSH_BACK, '0, '0);
    send_request(OP_DUMP_FWD, '0, '0);
    send_request(OP_DUMP_BWD, '0, '0);
    send_request(OP_POP_FRONT, '0, '0);
    send_request(OP_POP_BACK, '0, '0);
    send_request(OP_POP_BACK, '0, '0);
    send_request(OP_PUSH_BACK, 64'h0706050403020100, 56'h0e0d0c0b0a0908);
    send_request(OP_POP_FRONT, '0, '0);
    send_request(OP_DUMP_FWD, '0, '0);
    finish_phase();
  endtask

  task automatic test_fill_under_backpressure();
    hold_left = HOLD_OFF_CYCLES;
    repeat (10) send_request(OP_PUSH_BACK, pick_low(), pick_high());
    repeat (8) send_request(OP_PUSH_FRONT, pick_low(), pick_high());
    send_request(OP_DUMP_FWD, '0, '0);
    send_request(OP_DUMP_BWD, '0, '0);
    repeat (9) send_request(OP_POP_FRONT, '0, '0);
    repeat (9) send_request(OP_POP_BACK, '0, '0);
    finish_phase();
  endtask

  task automatic run_mixed_traffic(int n_items);
    int sent;
    int r;
    bit filling;
    logic [2:0] op;
    sent = 0;
    filling = 1'b1;
    while (sent < n_items) begin
      if (filling && ring_count == DEPTH && $urandom_range(0, 3) == 0) filling = 1'b0;
      if (!filling && ring_count == 0 && $urandom_range(0, 3) == 0) filling = 1'b1;
      r = $urandom_range(0, 99);
      if (r < 3)
        op = $urandom_range(0, 1) ? OP_SPARE_6 : OP_SPARE_7;
      else if (r < (filling ? 58 : 28))
        op = $urandom_range(0, 1) ? OP_PUSH_FRONT : OP_PUSH_BACK;
      else if (r < 85)
        op = $urandom_range(0, 1) ? OP_POP_FRONT : OP_POP_BACK;
      else
        op = $urandom_range(0, 1) ? OP_DUMP_FWD : OP_DUMP_BWD;
      send_request(op, pick_low(), pick_high());
      if (op != OP_SPARE_6 && op != OP_SPARE_7) sent++;
    end
    finish_phase();
  endtask

  task automatic test_random_traffic();
    idle_on = 1'b1;
    run_mixed_traffic(380);
  endtask

  task automatic test_steady_stream();
    idle_on = 1'b0;
    run_mixed_traffic(120);
    idle_on = 1'b1;
  endtask

  initial begin
    req_if.valid = 1'b0;
    req_if.opcode = '0;
    req_if.text_low = '0;
    req_if.text_high = '0;
    rsp_if.ready = 1'b0;
    ring_front = '0;
    ring_count = '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_empty_queue();
    test_single_entries();
    test_fill_under_backpressure();
    test_random_traffic();
    test_steady_stream();
    if (mismatch_count == 0) begin
      $display("double_ended_queue_unit: match");
    end else begin
      $display("double_ended_queue_unit: mismatch");
    end
    $finish;
  end

endmodule
